>>> design/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache tag block.
package salc_pkg;

    localparam int ADDR_W = 48;
    localparam int CNT_W  = 48;
    localparam int OUT_W  = 152;
    localparam int PAD_W  = OUT_W - 2 - 3 * CNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

>>> design/salc_ctrl.sv
// Controller state machine: clearing pass, word acceptance and commit sequencing.
module salc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output salc_pkg::cmd_t    cmd,
    input  salc_pkg::status_t st
);

    salc_pkg::state_t state_reg;
    salc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= salc_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.clear_wr = 1'b0;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            salc_pkg::ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (st.clr_last) begin
                    state_next = salc_pkg::ST_IDLE;
                end
            end
            salc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = salc_pkg::ST_LOOKUP;
                end
            end
            salc_pkg::ST_LOOKUP: begin
                if (st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = salc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = salc_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

>>> design/salc_dp.sv
// Datapath: set memory, tag compare, LRU update, counters and the output register.
module salc_dp #(
    parameter int WAYS             = 4,
    parameter int SET_INDEX_BITS   = 8,
    parameter int LINE_OFFSET_BITS = 6,
    parameter int ADDRESS_BITS     = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [salc_pkg::ADDR_W-1:0] s_tdata,
    input  salc_pkg::cmd_t              cmd,
    output salc_pkg::status_t           st,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [salc_pkg::OUT_W-1:0]  m_tdata
);

    localparam int EFF_AB = (ADDRESS_BITS < salc_pkg::ADDR_W) ? ADDRESS_BITS
                                                                : salc_pkg::ADDR_W;
    localparam int TAG_W  = EFF_AB - LINE_OFFSET_BITS - SET_INDEX_BITS;
    localparam int RW     = $clog2(WAYS);
    localparam int WAY_W  = 1 + RW + TAG_W;
    localparam int ROW_W  = WAYS * WAY_W;
    localparam int SETS   = 1 << SET_INDEX_BITS;
    localparam logic [RW-1:0] OLDEST = RW'(WAYS - 1);

    logic [ROW_W-1:0]          mem [SETS];
    logic [ROW_W-1:0]          rd_row_reg;
    logic [ROW_W-1:0]          new_row;
    logic [SET_INDEX_BITS-1:0] set_reg;
    logic [TAG_W-1:0]          tag_reg;
    logic [SET_INDEX_BITS-1:0] clr_idx_reg;

    logic                      vld  [WAYS];
    logic [RW-1:0]             rank [WAYS];
    logic [TAG_W-1:0]          tagw [WAYS];

    logic                      hit_found;
    logic                      free_found;
    logic [RW-1:0]             hit_way;
    logic [RW-1:0]             free_way;
    logic [RW-1:0]             old_way;
    logic [RW-1:0]             hit_rank;
    logic [RW-1:0]             target;
    logic                      was_mru;
    logic                      age;

    logic [salc_pkg::CNT_W-1:0] acc_reg;
    logic [salc_pkg::CNT_W-1:0] hit_cnt_reg;
    logic [salc_pkg::CNT_W-1:0] mru_cnt_reg;
    logic                       hit_reg;
    logic                       mru_reg;
    logic                       m_tvalid_reg;

    assign st.clr_last = (clr_idx_reg == {SET_INDEX_BITS{1'b1}});
    assign st.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) begin
            mem[clr_idx_reg] <= '0;
        end else if (cmd.commit) begin
            mem[set_reg] <= new_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_row_reg <= mem[s_tdata[LINE_OFFSET_BITS +: SET_INDEX_BITS]];
            set_reg    <= s_tdata[LINE_OFFSET_BITS +: SET_INDEX_BITS];
            tag_reg    <= s_tdata[LINE_OFFSET_BITS + SET_INDEX_BITS +: TAG_W];
        end
    end

    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        old_way    = '0;
        for (int w = 0; w < WAYS; w++) begin
            vld[w]  = rd_row_reg[w * WAY_W];
            rank[w] = rd_row_reg[w * WAY_W + 1 +: RW];
            tagw[w] = rd_row_reg[w * WAY_W + 1 + RW +: TAG_W];
        end
        for (int w = 0; w < WAYS; w++) begin
            if (vld[w]) begin
                if (!hit_found && tagw[w] == tag_reg) begin
                    hit_found = 1'b1;
                    hit_way   = RW'(w);
                end
                if (rank[w] == OLDEST) begin
                    old_way = RW'(w);
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_way   = RW'(w);
            end
        end
        hit_rank = rank[hit_way];
        was_mru  = hit_found && (hit_rank == '0);
        target   = hit_found ? hit_way : (free_found ? free_way : old_way);
        new_row  = '0;
        for (int w = 0; w < WAYS; w++) begin
            priority if (hit_found) begin
                age = rank[w] < hit_rank;
            end else if (free_found) begin
                age = 1'b1;
            end else begin
                age = rank[w] < OLDEST;
            end
            if (RW'(w) == target) begin
                new_row[w * WAY_W +: WAY_W] = {tag_reg, {RW{1'b0}}, 1'b1};
            end else if (vld[w] && age) begin
                new_row[w * WAY_W +: WAY_W] = {tagw[w], rank[w] + 1'b1, 1'b1};
            end else begin
                new_row[w * WAY_W +: WAY_W] = {tagw[w], rank[w], vld[w]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            hit_cnt_reg  <= '0;
            mru_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
                if (acc_reg != salc_pkg::CNT_MAX) begin
                    acc_reg <= acc_reg + 1'b1;
                end
                if (hit_found && hit_cnt_reg != salc_pkg::CNT_MAX) begin
                    hit_cnt_reg <= hit_cnt_reg + 1'b1;
                end
                if (was_mru && mru_cnt_reg != salc_pkg::CNT_MAX) begin
                    mru_cnt_reg <= mru_cnt_reg + 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_reg <= hit_found;
            mru_reg <= was_mru;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{salc_pkg::PAD_W{1'b0}}, mru_cnt_reg, hit_cnt_reg, acc_reg,
                       mru_reg, hit_reg};

endmodule

>>> design/set_assoc_lru_cache_tags.sv
// Top level of the set-associative cache tag model with true LRU replacement.
//
// Channel   Dir  Signals                      Contents
// s_        in   s_tvalid s_tready s_tdata    address[47:0]
// m_        out  m_tvalid m_tready m_tdata    hit, hit_was_mru, three 48-bit totals
//
// After reset a clearing pass writes every set, and no word is accepted until it ends.
// Each word is handled by the registered read of its set row, then by the tag compare,
// LRU update and write-back of that row.
// The result sits in an output register, so a new word is taken while it waits.
// A word whose result cannot be stored yet holds in the lookup step until it can.
module set_assoc_lru_cache_tags #(
    parameter int WAYS             = 4,
    parameter int SET_INDEX_BITS   = 8,
    parameter int LINE_OFFSET_BITS = 6,
    parameter int ADDRESS_BITS     = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // address
    input  logic [salc_pkg::ADDR_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // hit, hit_was_mru, access_total, hit_total, mru_hit_total, zero pad
    output logic [salc_pkg::OUT_W-1:0]  m_tdata
);

    salc_pkg::cmd_t    cmd;
    salc_pkg::status_t st;

    salc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    salc_dp #(
        .WAYS             (WAYS),
        .SET_INDEX_BITS   (SET_INDEX_BITS),
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
        .ADDRESS_BITS     (ADDRESS_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
